@@ sv/slr_pkg.sv @@
// Shared types and constants for the stereo linear resampler.
`timescale 1ns / 1ps
`default_nettype none
package slr_pkg;

  localparam int unsigned CHANNELS    = 2;
  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned CNT_W       = 3;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PHASE_W  = 18;
  localparam int unsigned SRC_W    = 17;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE_SEL = 1'd1;

  localparam logic [SRC_W-1:0] SOURCE_RATE_RST = 17'd32000;

  localparam logic [15:0] OUT_RATE_LOW  = 16'd32000;
  localparam logic [15:0] OUT_RATE_HIGH = 16'd48000;

  // Reciprocals for the divide by the output rate.
  // 32000 = 125 * 2^8 : q = ((m >> 8) * RECIP_32K) >> 30
  // 48000 = 375 * 2^7 : q = ((m >> 7) * RECIP_48K) >> 33
  localparam logic [24:0] RECIP_32K = 25'd8589935;
  localparam logic [24:0] RECIP_48K = 25'd22906493;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_cur;  // latch incoming frame, clear result count
    logic prime;     // first frame: store as previous, set primed
    logic mul;       // form the weighted sums
    logic div;       // reciprocal multiply, magnitude of quotient
    logic fix;       // apply sign, load output registers
    logic advance;   // result taken: phase += source rate, count++
    logic finish;    // end of frame: drop phase, cur becomes prev
  } slr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic primed;
    logic can_emit;  // phase below output rate and count below limit
    logic more;      // another result follows the one on the output
  } slr_sts_t;

endpackage
`default_nettype wire

@@ sv/stereo_linear_resampler_unit.sv @@
// Top level of the stereo linear resampler: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Linear-interpolation sample rate converter for stereo 16-bit frames. Each
// input transaction carries one frame; the first frame after reset only primes
// the block and yields no output. For every later frame the block emits zero
// to six output transactions, each the blend
// (prev*(out-phase) + cur*phase)/out truncated toward zero, with phase
// advancing by source_rate per output and dropping by the output rate (32000
// or 48000, out_rate_sel) at the end of the frame, saturating at zero.
// last_of_run marks the final output of a frame. Timing: one frame is taken
// at a time: in_stall_o stays high while a frame is being processed, until
// its last output is taken, so the block does not take a new frame before
// it is through with the last one. Each result passes through the single
// result pipeline: weighted-sum multiply, reciprocal multiply for the
// divide, sign fixup, then the output register, one result at a time.
// buffer_end_i is accepted with the frame but has no effect on the results.
// Configuration: cfg_idx_i 0 is source_rate (17 bits, reset 32000), 1 is
// out_rate_sel (reset 0); write only while the block is idle.
module stereo_linear_resampler_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [slr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [slr_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input frames
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0]  left_in_i,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0]  right_in_i,
  input  wire logic                                 buffer_end_i,
  // output samples
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [slr_pkg::SAMPLE_W-1:0]       left_out_o,
  output logic signed [slr_pkg::SAMPLE_W-1:0]       right_out_o,
  output logic                                      last_of_run_o
);
  import slr_pkg::*;

  slr_cmd_t cmd;
  slr_sts_t sts;

  slr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  slr_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .left_in_i     (left_in_i),
    .right_in_i    (right_in_i),
    .left_out_o    (left_out_o),
    .right_out_o   (right_out_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
`default_nettype wire

@@ sv/slr_ctrl.sv @@
// Controller state machine for the stereo linear resampler.
`timescale 1ns / 1ps
`default_nettype none
module slr_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  input  wire slr_pkg::slr_sts_t sts_i,
  output slr_pkg::slr_cmd_t     cmd_o
);
  import slr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FIX   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_cur = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts_i.primed) begin
          cmd_o.prime = 1'b1;
          state_d     = ST_IDLE;
        end else if (sts_i.can_emit) begin
          state_d = ST_MUL;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          cmd_o.advance = 1'b1;
          if (sts_i.more) begin
            state_d = ST_MUL;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

endmodule
`default_nettype wire

@@ sv/slr_datapath.sv @@
// Datapath of the stereo linear resampler: frame, phase, blend and divide lanes.
`timescale 1ns / 1ps
`default_nettype none
module slr_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire slr_pkg::slr_cmd_t                    cmd_i,
  output slr_pkg::slr_sts_t                         sts_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [slr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [slr_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0]  left_in_i,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0]  right_in_i,
  output logic signed [slr_pkg::SAMPLE_W-1:0]       left_out_o,
  output logic signed [slr_pkg::SAMPLE_W-1:0]       right_out_o,
  output logic                                      last_of_run_o
);
  import slr_pkg::*;

  // Configuration
  logic [SRC_W-1:0] src_rate_q;
  logic             rate_sel_q;

  // Frame and phase state
  logic signed [SAMPLE_W-1:0] cur_q  [CHANNELS];
  logic signed [SAMPLE_W-1:0] prev_q [CHANNELS];
  logic signed [SAMPLE_W-1:0] in_smp [CHANNELS];
  logic [PHASE_W-1:0]         phase_q, phase_adv, phase_nx;
  logic [CNT_W-1:0]           cnt_q;
  logic                       primed_q;

  // Stage registers, one lane per channel
  logic signed [31:0]         sum_q  [CHANNELS];
  logic [SAMPLE_W-1:0]        qmag_q [CHANNELS];
  logic                       neg_q  [CHANNELS];
  logic signed [SAMPLE_W-1:0] res_q  [CHANNELS];
  logic                       last_q;

  logic [15:0]        rate16;
  logic [PHASE_W-1:0] rate18;
  logic               last_d;

  assign rate16 = rate_sel_q ? OUT_RATE_HIGH : OUT_RATE_LOW;
  assign rate18 = PHASE_W'(rate16);
  assign in_smp[0] = left_in_i;
  assign in_smp[1] = right_in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rate_q <= SOURCE_RATE_RST;
      rate_sel_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SOURCE_RATE:  src_rate_q <= cfg_data_i[SRC_W-1:0];
        REG_OUT_RATE_SEL: rate_sel_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Phase after the current result is taken, and the end-of-frame drop.
  assign phase_nx  = phase_q + PHASE_W'(src_rate_q);
  assign phase_adv = cmd_i.advance ? phase_nx : phase_q;

  // Last result of the run: the loop condition fails for the next one.
  assign last_d = !((phase_nx < rate18) && (cnt_q != CNT_W'(MAX_RESULTS - 1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      cnt_q    <= '0;
      primed_q <= 1'b0;
    end else begin
      if (cmd_i.load_cur) begin
        cnt_q <= '0;
      end else if (cmd_i.advance) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.prime) begin
        primed_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        phase_q <= (phase_adv >= rate18) ? (phase_adv - rate18) : '0;
      end else if (cmd_i.advance) begin
        phase_q <= phase_adv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fix) begin
      last_q <= last_d;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic signed [SAMPLE_W:0]   diff;
    logic signed [33:0]         prod, base, sum34;
    logic [31:0]                mag;
    logic [23:0]                mdiv;
    logic [24:0]                recip;
    logic [48:0]                qprod;
    logic [SAMPLE_W-1:0]        qmag;

    // prev*(rate-phase) + cur*phase = prev*rate + (cur-prev)*phase
    assign diff  = $signed({cur_q[c][SAMPLE_W-1], cur_q[c]})
                 - $signed({prev_q[c][SAMPLE_W-1], prev_q[c]});
    assign prod  = diff * $signed({1'b0, phase_q[15:0]});
    assign base  = prev_q[c] * $signed({1'b0, rate16});
    assign sum34 = prod + base;

    // Truncating divide on the magnitude, by reciprocal multiply
    assign mag   = sum_q[c][31] ? 32'(-sum_q[c]) : 32'(sum_q[c]);
    assign mdiv  = rate_sel_q ? mag[30:7] : {1'b0, mag[30:8]};
    assign recip = rate_sel_q ? RECIP_48K : RECIP_32K;
    assign qprod = mdiv * recip;
    assign qmag  = rate_sel_q ? qprod[48:33] : qprod[45:30];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        prev_q[c] <= '0;
      end else if (cmd_i.prime || cmd_i.finish) begin
        prev_q[c] <= cur_q[c];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load_cur) begin
        cur_q[c] <= in_smp[c];
      end
      if (cmd_i.mul) begin
        sum_q[c] <= sum34[31:0];
      end
      if (cmd_i.div) begin
        qmag_q[c] <= qmag;
        neg_q[c]  <= sum_q[c][31];
      end
      if (cmd_i.fix) begin
        res_q[c] <= neg_q[c] ? $signed(-qmag_q[c]) : $signed(qmag_q[c]);
      end
    end
  end

  assign left_out_o    = res_q[0];
  assign right_out_o   = res_q[1];
  assign last_of_run_o = last_q;

  assign sts_o.primed   = primed_q;
  assign sts_o.can_emit = (phase_q < rate18) && (cnt_q < CNT_W'(MAX_RESULTS));
  assign sts_o.more     = !last_q;

endmodule
`default_nettype wire

@@ sv/slr_checker.sv @@
// Port-level assertions for the stereo linear resampler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module slr_checker (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  input  wire logic                                 in_stall_o,
  input  wire logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0]  left_out_o,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0]  right_out_o,
  input  wire logic                                 last_of_run_o
);

  // A stalled output transaction keeps its valid.
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("out_valid_o dropped while stalled");

  // A stalled output transaction keeps its payload.
  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(left_out_o) && $stable(right_out_o)
                                   && $stable(last_of_run_o))
    else $error("output payload changed while stalled");

  // While the block takes frames, no result is pending.
  a_idle_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("output valid while ready for a frame");

  // An accepted frame occupies the block in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("frame accepted but block not busy next cycle");

  // A result is never followed directly by a new result with no gap.
  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("back-to-back output transactions");

endmodule

bind stereo_linear_resampler_unit slr_checker u_slr_checker (.*);
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the stereo linear resampler unit.
`timescale 1ns / 1ps
// Frames go in on the input channel, interpolated samples come out on the
// output channel. A behavioral resampler below tracks the held frame, the
// phase accumulator and the register settings, and queues the samples each
// accepted frame should produce. The output monitor pops that queue in order.
// A short directed table covers priming, sample extremes and every rate
// corner. Random frames under random rate settings follow, in three
// handshake profiles.
module tb;
  import slr_pkg::*;

  localparam int SETTLE_CYCLES  = 40;    // block may still be busy after the last sample
  localparam int STALL_LIMIT    = 2000;  // cycles with no transaction before giving up
  localparam int SEGS_PER_PHASE = 4;
  localparam int FRAMES_PER_SEG = 20;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    last_run;
  } out_frame_t;

  // One row of the directed table: a register write or a frame.
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    sample_t               left;
    sample_t               right;
    logic                  bend;
    logic                  known;    // outputs typed into the row
    logic [CNT_W-1:0]      n_known;  // 0 or 1 output, equal to the held frame
    sample_t               known_l;
    sample_t               known_r;
  } step_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  sample_t               left_in;
  sample_t               right_in;
  logic                  buffer_end;
  logic                  out_valid;
  logic                  out_stall;
  sample_t               left_out;
  sample_t               right_out;
  logic                  last_of_run;

  // Behavioral copy of the block state and registers.
  sample_t          held_l;
  sample_t          held_r;
  logic [PHASE_W-1:0] acc_phase;
  logic             have_prev;
  logic [SRC_W-1:0] rate_in;
  logic             sel_48k;

  out_frame_t pending_samples[$];
  out_frame_t want;
  int         mismatch_cnt = 0;
  int         quiet_cycles = 0;
  int         snd_idle_pct;
  int         rcv_idle_pct;

  stereo_linear_resampler_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .left_in_i     (left_in),
    .right_in_i    (right_in),
    .buffer_end_i  (buffer_end),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .left_out_o    (left_out),
    .right_out_o   (right_out),
    .last_of_run_o (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append one expected sample to the tail of the queue.
  function automatic void queue_sample(out_frame_t s);
    pending_samples = {pending_samples, s};
  endfunction

  // Weighted blend of held and current sample, quotient truncated toward zero.
  function automatic sample_t lerp(sample_t a, sample_t b, int unsigned ph,
                                   int unsigned span);
    int mix;
    int q;
    mix = int'(a) * int'(span - ph) + int'(b) * int'(ph);
    q   = mix / int'(span);
    return q[SAMPLE_W-1:0];
  endfunction

  // Advance the behavioral state by one accepted frame; optionally queue
  // the samples it yields.
  task automatic resample_frame(input sample_t cur_l, input sample_t cur_r,
                                input bit queue_it);
    int unsigned span;
    out_frame_t  run [MAX_RESULTS];
    int          n;
    int          i;
    span = sel_48k ? OUT_RATE_HIGH : OUT_RATE_LOW;
    n    = 0;
    if (!have_prev) begin
      // priming frame: stored, no output, phase untouched
      have_prev = 1'b1;
    end else begin
      while (acc_phase < span && n < MAX_RESULTS) begin
        run[n].left     = lerp(held_l, cur_l, acc_phase, span);
        run[n].right    = lerp(held_r, cur_r, acc_phase, span);
        run[n].last_run = 1'b0;
        n++;
        acc_phase = acc_phase + rate_in;
      end
      if (n > 0) run[n-1].last_run = 1'b1;
      // drop by the output rate, saturating at zero for very low rates
      if (acc_phase >= span) acc_phase = acc_phase - span[PHASE_W-1:0];
      else acc_phase = '0;
      if (queue_it) begin
        for (i = 0; i < n; i++) queue_sample(run[i]);
      end
    end
    held_l = cur_l;
    held_r = cur_r;
  endtask

  function automatic step_t known_row(sample_t l, sample_t r, logic be,
                                      int n, sample_t el, sample_t er);
    step_t s;
    s         = '0;
    s.left    = l;
    s.right   = r;
    s.bend    = be;
    s.known   = 1'b1;
    s.n_known = n[CNT_W-1:0];
    s.known_l = el;
    s.known_r = er;
    return s;
  endfunction

  function automatic step_t frame_row(sample_t l, sample_t r, logic be);
    step_t s;
    s       = '0;
    s.left  = l;
    s.right = r;
    s.bend  = be;
    return s;
  endfunction

  function automatic step_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                    logic [CFG_DATA_W-1:0] val);
    step_t s;
    s         = '0;
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly in-range rates, with the edges and both out-of-range sides.
  function automatic logic [SRC_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0: return 17'd8000;
      1: return 17'd96000;
      2: return SRC_W'($urandom_range(0, 7999));
      3: return SRC_W'($urandom_range(96001, 131071));
      default: return SRC_W'($urandom_range(8000, 96000));
    endcase
  endfunction

  // Register write, only once the block has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    in_valid = 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_SOURCE_RATE:  rate_in = val[SRC_W-1:0];
      REG_OUT_RATE_SEL: sel_48k = val[0];
      default: ;
    endcase
  endtask

  // One input transaction. Called just after a falling edge, returns just
  // after the falling edge that follows acceptance.
  task automatic send_frame(input step_t st);
    out_frame_t e;
    int         i;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    left_in    = st.left;
    right_in   = st.right;
    buffer_end = st.bend;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    if (st.known) begin
      for (i = 0; i < st.n_known; i++) begin
        e.left     = st.known_l;
        e.right    = st.known_r;
        e.last_run = (i == st.n_known - 1);
        queue_sample(e);
      end
    end
    // rows with typed outputs still move the behavioral state along
    resample_frame(st.left, st.right, !st.known);
    @(negedge clk);
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < rcv_idle_pct);
  end

  // Output monitor: each output transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected output: left %0d right %0d last %0b",
                 $time, left_out, right_out, last_of_run);
        mismatch_cnt++;
      end else begin
        want = pending_samples.pop_front();
        if (left_out !== want.left) begin
          $display("%0t: left_out expected %0d got %0d", $time, want.left, left_out);
          mismatch_cnt++;
        end
        if (right_out !== want.right) begin
          $display("%0t: right_out expected %0d got %0d", $time, want.right, right_out);
          mismatch_cnt++;
        end
        if (last_of_run !== want.last_run) begin
          $display("%0t: last_of_run expected %0b got %0b", $time, want.last_run,
                   last_of_run);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: too long with no transaction on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    step_t                 plan[$];
    logic [CFG_DATA_W-1:0] cfg_word;
    int                    ph;
    int                    seg;
    int                    k;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_SOURCE_RATE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    left_in      = '0;
    right_in     = '0;
    buffer_end   = 1'b0;
    snd_idle_pct = 21;
    rcv_idle_pct = 81;
    held_l       = '0;
    held_r       = '0;
    acc_phase    = '0;
    have_prev    = 1'b0;
    rate_in      = SOURCE_RATE_RST;
    sel_48k      = 1'b0;

    // At reset rates (32000 in, 32000 out) each frame after priming yields
    // exactly the held frame, so those outputs are typed in.
    plan = {plan, known_row(-32768, 32767, 1'b0, 0, 0, 0)};  // priming only
    plan = {plan, known_row(32767, -32768, 1'b1, 1, -32768, 32767)};
    plan = {plan, known_row(0, 0, 1'b0, 1, 32767, -32768)};
    plan = {plan, known_row(-1, 1, 1'b1, 1, 0, 0)};
    plan = {plan, known_row(16'h5555, 16'haaaa, 1'b0, 1, -1, 1)};
    plan = {plan, known_row(16'haaaa, 16'h5555, 1'b1, 1, 16'h5555, 16'haaaa)};
    // lowest in-range rate: four outputs per frame
    plan = {plan, cfg_row(REG_SOURCE_RATE, 17'd8000)};
    plan = {plan, frame_row(32767, -32768, 1'b0)};
    plan = {plan, frame_row(-32768, 32767, 1'b1)};
    // 48 kHz out: six outputs per frame
    plan = {plan, cfg_row(REG_OUT_RATE_SEL, 17'd1)};
    plan = {plan, frame_row(32767, 32767, 1'b0)};
    // highest in-range rate: phase overshoots, some frames give nothing
    plan = {plan, cfg_row(REG_SOURCE_RATE, 17'd96000)};
    plan = {plan, frame_row(-32768, -32768, 1'b0)};
    plan = {plan, frame_row(12345, -12345, 1'b1)};
    plan = {plan, frame_row(-32768, 32767, 1'b0)};
    // zero rate: capped at six outputs, phase saturates to zero
    plan = {plan, cfg_row(REG_SOURCE_RATE, 17'd0)};
    plan = {plan, frame_row(32767, -32768, 1'b1)};
    plan = {plan, frame_row(-32768, 32767, 1'b0)};
    plan = {plan, cfg_row(REG_SOURCE_RATE, 17'd1)};
    plan = {plan, frame_row(1000, -1000, 1'b0)};
    // largest encodable rate, above range
    plan = {plan, cfg_row(REG_SOURCE_RATE, 17'h1ffff)};
    plan = {plan, frame_row(32767, -32768, 1'b1)};
    plan = {plan, frame_row(-7, 7, 1'b0)};
    plan = {plan, frame_row(-32768, 32767, 1'b1)};
    // back to 32 kHz, upper data bits set on the select write
    plan = {plan, cfg_row(REG_OUT_RATE_SEL, 17'h1fffe)};
    plan = {plan, frame_row(-32768, 32767, 1'b0)};

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_frame(plan[i]);
    end

    // Random part: sender-idle / receiver-stall profiles, then no idling.
    for (ph = 0; ph < 3; ph++) begin
      write_reg(REG_SOURCE_RATE, pick_rate());  // drains before the profile changes
      snd_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 81 : 0;
      rcv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 21 : 0;
      for (seg = 0; seg < SEGS_PER_PHASE; seg++) begin
        if (seg != 0) write_reg(REG_SOURCE_RATE, pick_rate());
        cfg_word = CFG_DATA_W'($urandom);
        write_reg(REG_OUT_RATE_SEL, cfg_word);
        for (k = 0; k < FRAMES_PER_SEG; k++) begin
          send_frame(frame_row(rand_sample(), rand_sample(), 1'($urandom_range(0, 1))));
        end
      end
    end

    in_valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_samples.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
